### design/spem_pkg.sv
// Shared types, constants and arithmetic helpers for the separable power edge mask.
`default_nettype none
package spem_pkg;

    localparam int DIM_W       = 13;
    localparam int MU_W        = 5;
    localparam int PIX_W       = 16;
    localparam int OUT_W       = 18;
    localparam int QUO_W       = 17;
    localparam int RAT_W       = 18;
    localparam int FAC_W       = 19;
    localparam int REM_W       = 32;
    localparam int DIV_STAGES  = QUO_W;
    localparam int POW_STAGES  = (1 << MU_W) - 1;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam int DEFAULT_MAX_DIMENSION = 4096;
    localparam int DIM_LIMIT             = (1 << DIM_W) - 1;

    localparam logic [DIM_W-1:0] RESET_WIDTH    = DIM_W'(512);
    localparam logic [DIM_W-1:0] RESET_HEIGHT   = DIM_W'(512);
    localparam logic [MU_W-1:0]  RESET_EXPONENT = MU_W'(2);

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(2);

    typedef struct packed {
        logic signed [PIX_W-1:0] pix;
        logic                    last;
        logic                    x_neg;
        logic [DIM_W-1:0]        x_mag;
        logic                    y_neg;
        logic [DIM_W-1:0]        y_mag;
    } entry_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
    } div_axis_t;

    typedef struct packed {
        logic signed [RAT_W-1:0] ratio;
        logic signed [RAT_W-1:0] pw;
    } pow_axis_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W:0]   hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_W'(2))
            r = DIM_W'(2);
        else if ({1'b0, v} > hi)
            r = hi[DIM_W-1:0];
        return r;
    endfunction

    function automatic logic signed [RAT_W-1:0] rnd16(input logic signed [2*RAT_W-1:0] v);
        logic [2*RAT_W-1:0] mag;
        logic [2*RAT_W-1:0] q;
        logic [RAT_W-1:0]   t;
        mag = v[2*RAT_W-1] ? (~v + 1'b1) : v;
        q   = (mag + (2*RAT_W)'(32768)) >> 16;
        t   = q[RAT_W-1:0];
        return $signed(v[2*RAT_W-1] ? (~t + 1'b1) : t);
    endfunction

endpackage
`default_nettype wire

### design/spem_front.sv
// Front end: raster position tracking and distance-from-center classification.
`default_nettype none
module spem_front #(
    parameter int MAX_DIMENSION = spem_pkg::DEFAULT_MAX_DIMENSION
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic signed [spem_pkg::PIX_W-1:0] pixel_value,
    input  wire logic                              q_full,
    input  wire logic [spem_pkg::DIM_W-1:0]        width,
    input  wire logic [spem_pkg::DIM_W-1:0]        height,
    output logic                                   in_stall,
    output logic                                   push,
    output spem_pkg::entry_t                       entry
);

    localparam int POS_W = (MAX_DIMENSION > 8192) ? spem_pkg::DIM_W : $clog2(MAX_DIMENSION);

    logic [POS_W-1:0] col_pos_reg, col_pos_next;
    logic [POS_W-1:0] row_pos_reg, row_pos_next;

    logic [spem_pkg::DIM_W-1:0] col, row, wm1, hm1, cx, cy;
    logic                       last;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        wm1 = width - 1'b1;
        hm1 = height - 1'b1;
        cx  = width >> 1;
        cy  = height >> 1;
        col = (spem_pkg::DIM_W'(col_pos_reg) < width)  ? spem_pkg::DIM_W'(col_pos_reg) : wm1;
        row = (spem_pkg::DIM_W'(row_pos_reg) < height) ? spem_pkg::DIM_W'(row_pos_reg) : hm1;
        last         = 1'b0;
        col_pos_next = POS_W'(col + 1'b1);
        row_pos_next = POS_W'(row);
        if (col >= wm1)
        begin
            col_pos_next = '0;
            if (row >= hm1)
            begin
                row_pos_next = '0;
                last         = 1'b1;
            end
            else
            begin
                row_pos_next = POS_W'(row + 1'b1);
            end
        end
        entry.pix   = pixel_value;
        entry.last  = last;
        entry.x_neg = col < cx;
        entry.x_mag = (col < cx) ? (cx - col) : (col - cx);
        entry.y_neg = row < cy;
        entry.y_mag = (row < cy) ? (cy - row) : (row - cy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (push)
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

endmodule
`default_nettype wire

### design/spem_queue.sv
// Short queue decoupling the front end from the arithmetic back end.
`default_nettype none
module spem_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire spem_pkg::entry_t push_entry,
    input  wire logic             pop,
    output logic                  full,
    output logic                  valid,
    output spem_pkg::entry_t      head
);

    localparam int PTR_W = $clog2(spem_pkg::QUEUE_DEPTH);

    spem_pkg::entry_t mem_reg [spem_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;

    assign full  = count_reg == (PTR_W+1)'(spem_pkg::QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

### design/spem_back.sv
// Back end: pipelined ratio divider, power chain, window multiply and output register.
`default_nettype none
module spem_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_valid,
    input  wire spem_pkg::entry_t                   q_entry,
    output logic                                    q_pop,
    input  wire logic [spem_pkg::DIM_W-1:0]         cx,
    input  wire logic [spem_pkg::DIM_W-1:0]         cy,
    input  wire logic [spem_pkg::MU_W-1:0]          mu,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [spem_pkg::OUT_W-1:0]       masked_value,
    output logic                                    frame_end
);

    localparam int D_N   = spem_pkg::DIV_STAGES;
    localparam int P_N   = spem_pkg::POW_STAGES;
    localparam int CH    = D_N + 1 + P_N + 1;
    localparam int M1_W  = spem_pkg::PIX_W + spem_pkg::FAC_W;
    localparam int M2_W  = M1_W + spem_pkg::FAC_W;
    localparam int QI_W  = $clog2(spem_pkg::QUO_W);
    localparam int RS_W  = M2_W - 32 + 1;

    spem_pkg::div_axis_t div_x_reg [D_N+1];
    spem_pkg::div_axis_t div_y_reg [D_N+1];
    spem_pkg::pow_axis_t pow_x_reg [P_N+1];
    spem_pkg::pow_axis_t pow_y_reg [P_N+1];

    logic signed [spem_pkg::PIX_W-1:0] pix_reg  [CH];
    logic                              last_reg [CH+2];
    logic                              vld_reg  [CH+2];

    logic signed [M1_W-1:0]               m1_reg;
    logic signed [spem_pkg::FAC_W-1:0]    fy_reg;
    logic signed [M2_W-1:0]               m2_reg;
    logic signed [spem_pkg::FAC_W-1:0]    fx_next, fy_next;

    logic                              out_valid_reg;
    logic signed [spem_pkg::OUT_W-1:0] masked_reg, masked_next;
    logic                              frame_end_reg;

    logic [M2_W-1:0] m2_mag;
    logic [M2_W-1:0] m2_q;
    logic signed [RS_W-1:0] m2_s;
    logic en;

    function automatic spem_pkg::div_axis_t div_step(input spem_pkg::div_axis_t s,
                                                     input logic [spem_pkg::DIM_W:0] d2,
                                                     input logic [QI_W-1:0] b);
        spem_pkg::div_axis_t r;
        logic [spem_pkg::REM_W-1:0] sh;
        logic [spem_pkg::REM_W:0]   t;
        r  = s;
        sh = spem_pkg::REM_W'(d2) << b;
        t  = {1'b0, s.rem} - {1'b0, sh};
        if (!t[spem_pkg::REM_W])
        begin
            r.rem    = t[spem_pkg::REM_W-1:0];
            r.quo[b] = 1'b1;
        end
        return r;
    endfunction

    function automatic spem_pkg::pow_axis_t pow_load(input spem_pkg::div_axis_t s);
        spem_pkg::pow_axis_t r;
        logic signed [spem_pkg::RAT_W-1:0] q;
        q       = $signed({1'b0, s.quo});
        r.ratio = s.neg ? -q : q;
        r.pw    = spem_pkg::RAT_W'(65536);
        return r;
    endfunction

    function automatic spem_pkg::pow_axis_t pow_step(input spem_pkg::pow_axis_t s,
                                                     input logic on);
        spem_pkg::pow_axis_t r;
        logic signed [2*spem_pkg::RAT_W-1:0] prod;
        r    = s;
        prod = (2*spem_pkg::RAT_W)'($signed(s.pw)) * (2*spem_pkg::RAT_W)'($signed(s.ratio));
        if (on)
            r.pw = spem_pkg::rnd16(prod);
        return r;
    endfunction

    assign en    = !out_valid_reg || !out_stall;
    assign q_pop = en && q_valid;

    always_comb
    begin
        fx_next = spem_pkg::FAC_W'(65536) - spem_pkg::FAC_W'($signed(pow_x_reg[P_N].pw));
        fy_next = spem_pkg::FAC_W'(65536) - spem_pkg::FAC_W'($signed(pow_y_reg[P_N].pw));
        m2_mag  = m2_reg[M2_W-1] ? (~m2_reg + 1'b1) : m2_reg;
        m2_q    = (m2_mag + (M2_W'(1) << 31)) >> 32;
        m2_s    = m2_reg[M2_W-1] ? -$signed(m2_q[RS_W-1:0]) : $signed(m2_q[RS_W-1:0]);
        if (m2_s > RS_W'(131071))
            masked_next = spem_pkg::OUT_W'(131071);
        else if (m2_s < -RS_W'(131072))
            masked_next = -spem_pkg::OUT_W'(131072);
        else
            masked_next = m2_s[spem_pkg::OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_x_reg[0] <= '{rem: spem_pkg::REM_W'({q_entry.x_mag, 17'b0})
                                   + spem_pkg::REM_W'(cx),
                              quo: '0, neg: q_entry.x_neg};
            div_y_reg[0] <= '{rem: spem_pkg::REM_W'({q_entry.y_mag, 17'b0})
                                   + spem_pkg::REM_W'(cy),
                              quo: '0, neg: q_entry.y_neg};
            for (int j = 0; j < D_N; j++)
            begin
                div_x_reg[j+1] <= div_step(div_x_reg[j], {cx, 1'b0}, QI_W'(D_N-1-j));
                div_y_reg[j+1] <= div_step(div_y_reg[j], {cy, 1'b0}, QI_W'(D_N-1-j));
            end
            pow_x_reg[0] <= pow_load(div_x_reg[D_N]);
            pow_y_reg[0] <= pow_load(div_y_reg[D_N]);
            for (int k = 0; k < P_N; k++)
            begin
                pow_x_reg[k+1] <= pow_step(pow_x_reg[k], spem_pkg::MU_W'(k) < mu);
                pow_y_reg[k+1] <= pow_step(pow_y_reg[k], spem_pkg::MU_W'(k) < mu);
            end
            pix_reg[0]  <= q_entry.pix;
            last_reg[0] <= q_entry.last;
            for (int c = 0; c < CH-1; c++)
                pix_reg[c+1] <= pix_reg[c];
            for (int c = 0; c < CH+1; c++)
                last_reg[c+1] <= last_reg[c];
            m1_reg <= M1_W'(pix_reg[CH-1]) * M1_W'(fx_next);
            fy_reg <= fy_next;
            m2_reg <= M2_W'(m1_reg) * M2_W'(fy_reg);
            masked_reg    <= masked_next;
            frame_end_reg <= last_reg[CH+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CH+2; c++)
                vld_reg[c] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= q_valid;
            for (int c = 0; c < CH+1; c++)
                vld_reg[c+1] <= vld_reg[c];
            out_valid_reg <= vld_reg[CH+1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign masked_value = masked_reg;
    assign frame_end    = frame_end_reg;

endmodule
`default_nettype wire

### design/separable_power_edge_mask_core.sv
// Top level of the separable power edge mask: configuration registers and block wiring.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     pixel_value
//   out      output     out_valid / out_stall   masked_value, frame_end
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel per clock sustained while out_stall is low; the path from input transfer to output
// valid runs through the 17-stage ratio divider and the 31-stage power chain.
// Reset clears positions, queue, pipeline valids and loads the default registers.
// An output stall while out_valid is high freezes the back pipeline; the queue then fills and stalls the input.
`default_nettype none
module separable_power_edge_mask_core #(
    parameter int MAX_DIMENSION = spem_pkg::DEFAULT_MAX_DIMENSION
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [spem_pkg::PIX_W-1:0]     pixel_value,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [spem_pkg::OUT_W-1:0]          masked_value,
    output logic                                       frame_end,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [spem_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [spem_pkg::DIM_W-1:0]            cfg_data
);

    localparam logic [spem_pkg::DIM_W:0] DIM_HI =
        (MAX_DIMENSION > spem_pkg::DIM_LIMIT) ? (spem_pkg::DIM_W+1)'(spem_pkg::DIM_LIMIT)
                                              : (spem_pkg::DIM_W+1)'(MAX_DIMENSION);

    logic [spem_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [spem_pkg::MU_W-1:0]  mu_reg;

    logic             push, q_full, q_valid, q_pop;
    spem_pkg::entry_t push_entry, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= spem_pkg::clamp_dim(spem_pkg::RESET_WIDTH, DIM_HI);
            height_reg <= spem_pkg::clamp_dim(spem_pkg::RESET_HEIGHT, DIM_HI);
            mu_reg     <= spem_pkg::RESET_EXPONENT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                spem_pkg::REG_WIDTH:    width_reg  <= spem_pkg::clamp_dim(cfg_data, DIM_HI);
                spem_pkg::REG_HEIGHT:   height_reg <= spem_pkg::clamp_dim(cfg_data, DIM_HI);
                spem_pkg::REG_EXPONENT: mu_reg     <= cfg_data[spem_pkg::MU_W-1:0];
                default:                ;
            endcase
        end
    end

    spem_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .pixel_value(pixel_value),
        .q_full     (q_full),
        .width      (width_reg),
        .height     (height_reg),
        .in_stall   (in_stall),
        .push       (push),
        .entry      (push_entry)
    );

    spem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    spem_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_entry     (q_head),
        .q_pop       (q_pop),
        .cx          (width_reg >> 1),
        .cy          (height_reg >> 1),
        .mu          (mu_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .masked_value(masked_value),
        .frame_end   (frame_end)
    );

endmodule
`default_nettype wire
